[hdl/bfwa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfwa_pkg
// Shared types and codes for the bounded FIFO window average core.
// ----------------------------------------------------------------------------
package bfwa_pkg;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_EVICTED  = 2'd1;
	localparam logic [1:0] ST_REMOVED  = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic [3:0] CAPACITY_RESET = 4'd5;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch request, decide pop
		logic pop;       // drop oldest entry, using the read data
		logic write;     // append latched entry
		logic div_init;  // start average division
		logic div_step;  // one quotient bit
		logic finish;    // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_remove;
		logic need_pop;
		logic empty;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

[hdl/bfwa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/bfwa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfwa_ctrl
// Sequencer for one request: read, pop, write, divide, deliver.
// ----------------------------------------------------------------------------
module bfwa_ctrl
	import bfwa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_READ   = 7'b0000010,
		S_POP    = 7'b0000100,
		S_WRITE  = 7'b0001000,
		S_DIVL   = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				if (sts.empty) begin
					state_d = S_FINISH;
				end else if (sts.need_pop) begin
					state_d = S_POP;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = sts.is_remove ? S_FINISH : S_WRITE;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_DIVL;
			end
			S_DIVL: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// accepted request always moves on to the read slot
	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_READ))
		else $error("accepted request did not start a read");

	// a finished result never overwrites one still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("result dropped while stalled");

endmodule

`default_nettype wire

[hdl/bfwa_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfwa_dpath
// Ring buffer pointers, running sum, serial divider and result register.
// ----------------------------------------------------------------------------
module bfwa_dpath
	import bfwa_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic        operation,
	input  wire logic [15:0] record_tag,
	input  wire logic [15:0] birth_year,
	input  wire logic        cfg_write_en,
	input  wire logic [3:0]  cfg_write_data,
	output logic      [1:0]  status,
	output logic      [15:0] year_average,
	output logic      [15:0] removed_tag,
	output logic      [15:0] removed_year
);

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = 16 + CNT_W;
	localparam int REM_W  = CNT_W + 1;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;

	// state
	logic [3:0]       cap_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;

	// latched request
	logic        op_q;
	logic [15:0] tag_q;
	logic [15:0] year_q;
	logic        need_pop_q;
	logic        empty_q;
	logic [15:0] rem_tag_q;
	logic [15:0] rem_year_q;

	// divider
	logic [SUM_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;

	// result register
	logic [1:0]  status_q;
	logic [15:0] avg_q;
	logic [15:0] rtag_q;
	logic [15:0] ryear_q;

	// ram
	logic [31:0]      rdata;
	logic [IDX_W-1:0] slot;
	logic [CNT_W:0]   slot_sum;

	// capacity clamp and full test
	logic [CMP_W-1:0] cap_w, eff_cap, count_w;
	logic             full;

	always_comb begin
		cap_w   = CMP_W'(cap_q);
		count_w = CMP_W'(count_q);
		if (cap_q == 4'd0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_w > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end else begin
			eff_cap = cap_w;
		end
		full = (count_w >= eff_cap);
	end

	// tail slot = (head + count) mod DEPTH, same before and after an eviction
	always_comb begin
		slot_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
		if (slot_sum >= (CNT_W + 1)'(DEPTH)) begin
			slot_sum = slot_sum - (CNT_W + 1)'(DEPTH);
		end
		slot = slot_sum[IDX_W-1:0];
	end

	bfwa_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (slot),
		.wdata ({tag_q, year_q}),
		.raddr (head_q),
		.rdata (rdata)
	);

	logic [SUM_W-1:0] rd_year_x, in_year_x, sum_neg, quo_neg;
	logic [REM_W-1:0] shifted, divisor;
	logic             ge;

	assign rd_year_x = {{(SUM_W - 16){rdata[15]}}, rdata[15:0]};
	assign in_year_x = {{(SUM_W - 16){year_q[15]}}, year_q};
	assign sum_neg   = -sum_q;
	assign quo_neg   = -quo_q;
	assign shifted   = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
	assign divisor   = REM_W'(count_q);
	assign ge        = (shifted >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAPACITY_RESET;
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			step_q  <= '0;
		end else begin
			if (cfg_write_en) begin
				cap_q <= cfg_write_data;
			end
			if (cmd.pop) begin
				sum_q   <= sum_q - rd_year_x;
				count_q <= count_q - CNT_W'(1);
				if (head_q == IDX_W'(DEPTH - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + IDX_W'(1);
				end
			end else if (cmd.write) begin
				sum_q   <= sum_q + in_year_x;
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.div_init) begin
				step_q <= STEP_W'(SUM_W);
			end else if (cmd.div_step) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			tag_q  <= record_tag;
			year_q <= birth_year;
			if (operation == OP_REMOVE) begin
				need_pop_q <= (count_q != '0);
				empty_q    <= (count_q == '0);
			end else begin
				need_pop_q <= full;
				empty_q    <= 1'b0;
			end
		end
		if (cmd.pop) begin
			rem_tag_q  <= rdata[31:16];
			rem_year_q <= rdata[15:0];
		end
		if (cmd.div_init) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_q[SUM_W-1] ? sum_neg : sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? (shifted - divisor) : shifted;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
		if (cmd.finish) begin
			if (op_q == OP_INSERT) begin
				status_q <= need_pop_q ? ST_EVICTED : ST_INSERTED;
				avg_q    <= neg_q ? quo_neg[15:0] : quo_q[15:0];
				rtag_q   <= '0;
				ryear_q  <= '0;
			end else begin
				status_q <= empty_q ? ST_EMPTY : ST_REMOVED;
				avg_q    <= '0;
				rtag_q   <= empty_q ? 16'd0 : rem_tag_q;
				ryear_q  <= empty_q ? 16'd0 : rem_year_q;
			end
		end
	end

	assign sts.is_remove = (op_q == OP_REMOVE);
	assign sts.need_pop  = need_pop_q;
	assign sts.empty     = empty_q;
	assign sts.div_last  = (step_q == STEP_W'(1));

	assign status       = status_q;
	assign year_average = avg_q;
	assign removed_tag  = rtag_q;
	assign removed_year = ryear_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop with no entries held");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (count_q < CNT_W'(DEPTH)))
		else $error("append into a full ring");

endmodule

`default_nettype wire

[hdl/bounded_fifo_window_average_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Insert: read, pop if full, append, divider init, serial division, finish result.
//   Quotient width SUM_W = 16 + clog2(DEPTH+1) (20 at DEPTH 8), one bit per cycle.
// Remove: read, pop, finish (no pop on empty); ring read goes via the RAM read register.
// One request at a time; the next is accepted in the cycle after the result is loaded.
// Reset (arst_n, async): queue empty, head 0, sum 0, capacity 5; ring contents undefined.
// ----------------------------------------------------------------------------
// bounded_fifo_window_average_core
// Bounded FIFO of tagged years with a truncated average reported on insert.
// ----------------------------------------------------------------------------
module bounded_fifo_window_average_core
	import bfwa_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// capacity register write
	input  wire logic        cfg_write_en,
	input  wire logic [3:0]  cfg_write_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [15:0] record_tag,
	input  wire logic [15:0] birth_year,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  status,
	output logic      [15:0] year_average,
	output logic      [15:0] removed_tag,
	output logic      [15:0] removed_year
);

	cmd_t cmd;
	sts_t sts;

	// Controller: walks one request through read, optional pop, append,
	// division and the result register. The result register sits between
	// the channels, so a new request is taken while a result still waits.
	bfwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: ring pointers, running sum of held years, capacity clamp,
	// restoring divider on the sum magnitude, and the result payload.
	bfwa_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.record_tag     (record_tag),
		.birth_year     (birth_year),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.status         (status),
		.year_average   (year_average),
		.removed_tag    (removed_tag),
		.removed_year   (removed_year)
	);

endmodule

`default_nettype wire

[dv/bfwa_window_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfwa_window_checker
// Watches both channels of the window average core and tracks the queue.
// It works out each result and compares it field by field with the core.
// ----------------------------------------------------------------------------
module bfwa_window_checker
	import bfwa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [3:0]  cfg_write_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [15:0] record_tag,
	input  logic [15:0] birth_year,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [15:0] year_average,
	input  logic [15:0] removed_tag,
	input  logic [15:0] removed_year,
	output int          outstanding,
	output int          errors
);

	localparam int RING = 8;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] average;
		logic [15:0] tag;
		logic [15:0] year;
	} window_outcome_t;

	// shadow of the queue
	logic        [15:0] tag_ring  [RING];
	logic signed [15:0] year_ring [RING];
	int                 head;
	int                 held;
	int                 year_total;
	logic        [3:0]  capacity;

	window_outcome_t outcomes_due[$];
	window_outcome_t got_front;

	function automatic void drop_oldest();
		year_total -= year_ring[head];
		head = (head + 1) % RING;
		held--;
	endfunction

	function automatic window_outcome_t fifo_step(logic op, logic [15:0] tag,
			logic signed [15:0] year);
		window_outcome_t r;
		int limit;
		int slot;
		r = '0;
		limit = (capacity == 4'd0) ? 1 : ((capacity > RING) ? RING : int'(capacity));
		if (op == OP_INSERT) begin
			r.status = ST_INSERTED;
			if (held >= limit) begin
				drop_oldest();
				r.status = ST_EVICTED;
			end
			slot = (head + held) % RING;
			tag_ring[slot] = tag;
			year_ring[slot] = year;
			year_total += year;
			held++;
			r.average = 16'(year_total / held);
		end else if (held == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.tag = tag_ring[head];
			r.year = year_ring[head];
			drop_oldest();
			r.status = ST_REMOVED;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			held = 0;
			year_total = 0;
			capacity = CAPACITY_RESET;
			outcomes_due.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					got_front = outcomes_due.pop_front();
					check_field("status", int'(got_front.status), int'(status));
					check_field("year_average", int'($signed(got_front.average)),
						int'($signed(year_average)));
					check_field("removed_tag", int'(got_front.tag), int'(removed_tag));
					check_field("removed_year", int'($signed(got_front.year)),
						int'($signed(removed_year)));
				end
			end
			if (cfg_write_en)
				capacity = cfg_write_data;
			if (in_valid && !in_stall)
				outcomes_due.push_back(fifo_step(operation, record_tag, birth_year));
			outstanding = outcomes_due.size();
		end
	end

endmodule

[dv/bounded_fifo_window_average_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_fifo_window_average_core_tb
// Drives insert and remove requests and capacity writes into the core with
// random gaps and stalls; the window checker predicts and compares results.
// ----------------------------------------------------------------------------
module bounded_fifo_window_average_core_tb;
	import bfwa_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int TAIL_CYCLES    = 40;
	localparam int PHASE_ITEMS    = 197;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write_en;
	logic [3:0]  cfg_write_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [15:0] record_tag;
	logic [15:0] birth_year;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [15:0] year_average;
	logic [15:0] removed_tag;
	logic [15:0] removed_year;

	int outstanding;
	int errors;
	int idle_cycles;

	// shared between the request driver and the result side
	bit quiet;      // no idling on either side
	bit hold_long;  // ask the result side for one long hold-off

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bounded_fifo_window_average_core #(.DEPTH(8)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.record_tag     (record_tag),
		.birth_year     (birth_year),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.year_average   (year_average),
		.removed_tag    (removed_tag),
		.removed_year   (removed_year)
	);

	bfwa_window_checker watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.record_tag     (record_tag),
		.birth_year     (birth_year),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.year_average   (year_average),
		.removed_tag    (removed_tag),
		.removed_year   (removed_year),
		.outstanding    (outstanding),
		.errors         (errors)
	);

	// Gap length: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request; entered and left at a falling edge. With no gap the
	// valid simply stays high and only the payload moves on.
	task automatic send_request(input logic op, input logic [15:0] tag,
			input logic [15:0] year);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		record_tag <= tag;
		birth_year <= year;
		// accepted at the first rising edge with stall low
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stop offering and wait until every result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Capacity is only written with the core idle.
	task automatic set_capacity(input logic [3:0] value);
		drain();
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Result side: random stalls, plus the one long hold-off on request.
	initial begin : result_side
		int n;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_long = 1'b0;
			end else begin
				n = idle_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// Watchdog: any handshake restarts the count.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [3:0] phase_cap [8];
		int         phase_ins [8];
		logic       op;
		logic [15:0] year;
		int k;
		int p;
		int i;

		phase_cap = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd7, 4'd2, 4'd5};
		phase_ins = '{50, 70, 30, 90, 50, 60, 40, 50};

		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = 4'd0;
		in_valid = 1'b0;
		operation = OP_INSERT;
		record_tag = 16'd0;
		birth_year = 16'd0;
		out_stall = 1'b0;
		quiet = 1'b0;
		hold_long = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part, capacity at its reset value of 5 ---
		send_request(OP_REMOVE, 16'h0000, 16'h0000);   // remove on empty
		send_request(OP_INSERT, 16'h0000, 16'h8000);
		send_request(OP_INSERT, 16'hFFFF, 16'h7FFF);
		send_request(OP_INSERT, 16'h8000, 16'hFFFF);
		send_request(OP_INSERT, 16'h7FFF, 16'h8000);
		send_request(OP_INSERT, 16'h1234, 16'h8000);   // now full
		send_request(OP_INSERT, 16'hAAAA, 16'h8000);   // evicts oldest
		send_request(OP_INSERT, 16'h5555, 16'h7FFF);   // evicts oldest
		repeat (6) send_request(OP_REMOVE, 16'hFFFF, 16'hFFFF);  // last one empty

		// capacity zero holds a single entry
		set_capacity(4'd0);
		send_request(OP_INSERT, 16'h0001, 16'd100);
		send_request(OP_INSERT, 16'h0002, 16'hFFF9);

		// capacity above the ring depth saturates; negative sums truncate
		set_capacity(4'd15);
		for (k = 0; k < 8; k++)
			send_request(OP_INSERT, 16'(k * 4099), 16'(-(3 * k + 1)));

		// lowered below the count: insert evicts one, count stays
		set_capacity(4'd2);
		send_request(OP_INSERT, 16'hC3C3, 16'h0007);

		// --- random part: one capacity and insert mix per phase ---
		for (p = 0; p < 8; p++) begin
			set_capacity(phase_cap[p]);
			quiet = (p == 3);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 1 && i == 40)
					hold_long = 1'b1;
				op = ($urandom_range(0, 99) < phase_ins[p]) ? OP_INSERT : OP_REMOVE;
				case ($urandom_range(0, 9))
					0: year = 16'h8000;
					1: year = 16'h7FFF;
					default: year = 16'($urandom_range(0, 65535));
				endcase
				send_request(op, 16'($urandom_range(0, 65535)), year);
			end
		end
		quiet = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
